[rtl/lprd_pkg.sv]
// Shared types and constants for the length-prefixed request deframer.
// No dependencies; imported by lprd_parser and the top level.
package lprd_pkg;

    localparam logic [7:0] MAGIC_FIRST  = 8'hAB;
    localparam logic [7:0] MAGIC_SECOND = 8'hCD;

    // Phase codes of the parser
    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_LEN_IF  = 4'd2;
    localparam logic [3:0] PH_DATA_IF = 4'd3;
    localparam logic [3:0] PH_LEN_M   = 4'd4;
    localparam logic [3:0] PH_DATA_M  = 4'd5;
    localparam logic [3:0] PH_LEN_PT  = 4'd6;
    localparam logic [3:0] PH_DATA_PT = 4'd7;
    localparam logic [3:0] PH_ID      = 4'd8;
    localparam logic [3:0] PH_PLEN    = 4'd9;
    localparam logic [3:0] PH_PARAM   = 4'd10;

    // Segment codes
    localparam logic [2:0] SEG_IF    = 3'd0;
    localparam logic [2:0] SEG_M     = 3'd1;
    localparam logic [2:0] SEG_PT    = 3'd2;
    localparam logic [2:0] SEG_PARAM = 3'd3;
    localparam logic [2:0] SEG_EMPTY = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [2:0]  segment;
        logic [7:0]  payload_byte;
        logic        segment_last;
        logic [31:0] request_id;
    } lprd_result_t;

endpackage

[rtl/lprd_parser.sv]
// Framing state machine: phase, prefix counter, word accumulator, remaining
// count and current id. Advances one byte per step. Depends on lprd_pkg.
module lprd_parser
    import lprd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    output lprd_result_t result
);

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] id_reg, id_next;

    logic [31:0] acc_shift;
    logic        word_done;
    logic        remain_last;
    logic [31:0] remain_dec;

    assign acc_shift   = {acc_reg[23:0], data_byte};
    assign word_done   = (count_reg == 2'd3);
    assign remain_last = (remain_reg[31:1] == 31'd0);
    assign remain_dec  = (remain_reg != 32'd0) ? remain_reg - 32'd1 : remain_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        id_next     = id_reg;
        result      = '0;

        case (phase_reg)
            PH_HUNT2:
            begin
                if (data_byte == MAGIC_SECOND)
                begin
                    phase_next = PH_LEN_IF;
                    count_next = 2'd0;
                    acc_next   = 32'd0;
                end
                else if (data_byte != MAGIC_FIRST)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_LEN_IF, PH_LEN_M, PH_LEN_PT:
            begin
                acc_next   = acc_shift;
                count_next = count_reg + 2'd1;
                if (word_done)
                begin
                    remain_next = acc_shift;
                    // Empty string: skip straight to the next prefix
                    if (acc_shift == 32'd0)
                        phase_next = phase_reg + 4'd2;
                    else
                        phase_next = phase_reg + 4'd1;
                end
            end
            PH_DATA_IF, PH_DATA_M, PH_DATA_PT:
            begin
                result.valid        = 1'b1;
                result.segment      = (phase_reg == PH_DATA_IF) ? SEG_IF :
                                      (phase_reg == PH_DATA_M) ? SEG_M : SEG_PT;
                result.payload_byte = data_byte;
                result.segment_last = remain_last;
                remain_next         = remain_dec;
                if (remain_last)
                    phase_next = phase_reg + 4'd1;
            end
            PH_ID:
            begin
                acc_next   = acc_shift;
                count_next = count_reg + 2'd1;
                if (word_done)
                begin
                    id_next    = acc_shift;
                    phase_next = PH_PLEN;
                end
            end
            PH_PLEN:
            begin
                acc_next   = acc_shift;
                count_next = count_reg + 2'd1;
                if (word_done)
                begin
                    remain_next = acc_shift;
                    if (acc_shift == 32'd0)
                    begin
                        result.valid        = 1'b1;
                        result.segment      = SEG_EMPTY;
                        result.segment_last = 1'b1;
                        result.request_id   = id_reg;
                        phase_next          = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_PARAM;
                    end
                end
            end
            PH_PARAM:
            begin
                result.valid        = 1'b1;
                result.segment      = SEG_PARAM;
                result.payload_byte = data_byte;
                result.segment_last = remain_last;
                result.request_id   = id_reg;
                remain_next         = remain_dec;
                if (remain_last)
                    phase_next = PH_ID;
            end
            default:
            begin
                phase_next = (data_byte == MAGIC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            count_reg  <= 2'd0;
            acc_reg    <= 32'd0;
            remain_reg <= 32'd0;
            id_reg     <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            id_reg     <= id_next;
        end
    end

endmodule

[rtl/length_prefixed_request_deframer_core.sv]
// Length-prefixed request deframer: input byte register, parser, result register.
// Depends on lprd_pkg and lprd_parser.
//
// Usage:
//   Input channel (in_valid, in_stall, data_byte) takes one stream byte per
//   transfer. The block hunts for the magic pair 0xAB 0xCD, reads three
//   length-prefixed header strings, then loops over request bodies (id,
//   length, parameter bytes).
//   Output channel (out_valid, out_stall, segment, payload_byte,
//   segment_last, request_id) carries at most one result per input byte.
//   Magic, length, id bytes give no result, save an empty marker for length 0.
// Result path: a byte accepted into the input register passes through the
//   parser logic into the result register, visible there until taken.
// Throughput: one byte per clock unless out_stall holds a pending result; the
//   parser step is a single pass of short logic from input to result register.
// Stall: when out_stall holds a pending result, the byte in the input
//   register waits and in_stall rises; nothing is dropped.
// Reset: rst_n clears both registers' valid bits and returns the parser to
//   hunting the first magic byte.
module length_prefixed_request_deframer_core
    import lprd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  segment,
    output logic [7:0]  payload_byte,
    output logic        segment_last,
    output logic [31:0] request_id
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    lprd_result_t out_reg;
    lprd_result_t step_result;
    logic         out_free;
    logic         step;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    // Hold the input while its byte cannot move on
    assign in_stall = in_valid_reg && !out_free;

    lprd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= step && step_result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= data_byte;
        if (step && step_result.valid && out_free)
            out_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign segment      = out_reg.segment;
    assign payload_byte = out_reg.payload_byte;
    assign segment_last = out_reg.segment_last;
    assign request_id   = out_reg.request_id;

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.segment == SEG_EMPTY |->
            out_reg.payload_byte == 8'd0 && out_reg.segment_last)
        else $error("empty-parameter marker malformed");

    a_header_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.segment == SEG_IF || out_reg.segment == SEG_M ||
            out_reg.segment == SEG_PT) |-> out_reg.request_id == 32'd0)
        else $error("header segment carries a request id");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte lost or changed");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        step && step_result.valid |=> out_valid_reg)
        else $error("parser result not captured");

endmodule
